### sv/mnv_pkg.sv
// Package for the mailbox name validator core.
// Holds byte constants, verdict codes and the running state type; no dependencies.
package mnv_pkg;

	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_END     = 8'h00;

	localparam int DATA_W = 8;
	localparam int OUT_W  = 8;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_EMPTY     = 3'd1;
	localparam logic [2:0] ERR_UTF8      = 3'd2;
	localparam logic [2:0] ERR_EDGE      = 3'd3;
	localparam logic [2:0] ERR_CONTROL   = 3'd4;
	localparam logic [2:0] ERR_WILDCARD  = 3'd5;
	localparam logic [2:0] ERR_EMPTY_SEG = 3'd6;

	localparam logic [2:0] CLS_FULL = 3'd0;
	localparam logic [2:0] CLS_A0BF = 3'd1;
	localparam logic [2:0] CLS_809F = 3'd2;
	localparam logic [2:0] CLS_90BF = 3'd3;
	localparam logic [2:0] CLS_808F = 3'd4;

	localparam logic [1:0] PAT_NONE     = 2'd0;
	localparam logic [1:0] PAT_WILDCARD = 2'd1;
	localparam logic [1:0] PAT_DSLASH   = 2'd2;

	typedef struct packed {
		logic       seen_any;
		logic       first_is_slash;
		logic       prev_is_slash;
		logic       encoding_bad;
		logic [1:0] continuations_left;
		logic [2:0] second_byte_class;
		logic       after_c2_lead;
		logic       control_seen;
		logic [1:0] first_pattern_error;
	} name_state_t;

	function automatic logic cont_in_range(input logic [7:0] b, input logic [2:0] cls);
		logic r;
		case (cls)
			CLS_A0BF: r = b inside {[8'hA0:8'hBF]};
			CLS_809F: r = b inside {[8'h80:8'h9F]};
			CLS_90BF: r = b inside {[8'h90:8'hBF]};
			CLS_808F: r = b inside {[8'h80:8'h8F]};
			default:  r = b inside {[8'h80:8'hBF]};
		endcase
		return r;
	endfunction

endpackage

### sv/mailbox_name_validator_core.sv
// Mailbox name validator core: byte stream in, one verdict per zero-terminated name.
// Input register, state update and verdict logic, output register; depends on mnv_pkg.
// The terminator is held in the input register, its verdict in the output register driving m_axis_tvalid.
// Throughput: one byte per cycle; the input register holds only a terminator that
// meets a full, unaccepted output register.
// Reset (arst_n low, asynchronous): both registers empty, all running flags cleared.
module mailbox_name_validator_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [mnv_pkg::DATA_W-1:0] s_axis_tdata,   // [7:0] data_byte
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [mnv_pkg::OUT_W-1:0]  m_axis_tdata    // [0] name_ok, [3:1] error_code, [7:4] zero
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 out_valid_q;
	logic [2:0]           code_q;
	mnv_pkg::name_state_t st_q;
	mnv_pkg::name_state_t st_nx;
	logic                 is_end;
	logic                 out_free;
	logic                 take_s1;
	logic                 load_out;
	logic [2:0]           code_nx;

	assign is_end   = (byte_s1 == mnv_pkg::CH_END);
	assign out_free = !out_valid_q || m_axis_tready;
	assign take_s1  = valid_s1 && (!is_end || out_free);
	assign load_out = valid_s1 && is_end && out_free;

	assign s_axis_tready = !valid_s1 || take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	always_comb begin
		if (!st_q.seen_any)
			code_nx = mnv_pkg::ERR_EMPTY;
		else if (st_q.encoding_bad || st_q.continuations_left != 2'd0)
			code_nx = mnv_pkg::ERR_UTF8;
		else if (st_q.first_is_slash || st_q.prev_is_slash)
			code_nx = mnv_pkg::ERR_EDGE;
		else if (st_q.control_seen)
			code_nx = mnv_pkg::ERR_CONTROL;
		else if (st_q.first_pattern_error == mnv_pkg::PAT_WILDCARD)
			code_nx = mnv_pkg::ERR_WILDCARD;
		else if (st_q.first_pattern_error == mnv_pkg::PAT_DSLASH)
			code_nx = mnv_pkg::ERR_EMPTY_SEG;
		else
			code_nx = mnv_pkg::ERR_NONE;
	end

	always_comb begin
		st_nx = st_q;
		if (is_end) begin
			st_nx = '0;
		end else begin
			if (!st_q.encoding_bad) begin
				if (st_q.continuations_left == 2'd0) begin
					st_nx.second_byte_class = mnv_pkg::CLS_FULL;
					st_nx.after_c2_lead     = 1'b0;
					if (byte_s1 < 8'h80) begin
						if (byte_s1 < 8'h20 || byte_s1 == 8'h7F)
							st_nx.control_seen = 1'b1;
					end else if (byte_s1 < 8'hC2) begin
						st_nx.encoding_bad = 1'b1;
					end else if (byte_s1 <= 8'hDF) begin
						st_nx.continuations_left = 2'd1;
						st_nx.after_c2_lead      = (byte_s1 == 8'hC2);
					end else if (byte_s1 <= 8'hEF) begin
						st_nx.continuations_left = 2'd2;
						if (byte_s1 == 8'hE0)
							st_nx.second_byte_class = mnv_pkg::CLS_A0BF;
						else if (byte_s1 == 8'hED)
							st_nx.second_byte_class = mnv_pkg::CLS_809F;
					end else if (byte_s1 <= 8'hF4) begin
						st_nx.continuations_left = 2'd3;
						if (byte_s1 == 8'hF0)
							st_nx.second_byte_class = mnv_pkg::CLS_90BF;
						else if (byte_s1 == 8'hF4)
							st_nx.second_byte_class = mnv_pkg::CLS_808F;
					end else begin
						st_nx.encoding_bad = 1'b1;
					end
				end else if (!mnv_pkg::cont_in_range(byte_s1, st_q.second_byte_class)) begin
					st_nx.encoding_bad = 1'b1;
				end else begin
					if (st_q.after_c2_lead && byte_s1 <= 8'h9F)
						st_nx.control_seen = 1'b1;
					st_nx.after_c2_lead      = 1'b0;
					st_nx.second_byte_class  = mnv_pkg::CLS_FULL;
					st_nx.continuations_left = st_q.continuations_left - 2'd1;
				end
			end
			if (st_q.first_pattern_error == mnv_pkg::PAT_NONE) begin
				if (byte_s1 == mnv_pkg::CH_STAR || byte_s1 == mnv_pkg::CH_PERCENT)
					st_nx.first_pattern_error = mnv_pkg::PAT_WILDCARD;
				else if (byte_s1 == mnv_pkg::CH_SLASH && st_q.prev_is_slash)
					st_nx.first_pattern_error = mnv_pkg::PAT_DSLASH;
			end
			if (!st_q.seen_any && byte_s1 == mnv_pkg::CH_SLASH)
				st_nx.first_is_slash = 1'b1;
			st_nx.seen_any      = 1'b1;
			st_nx.prev_is_slash = (byte_s1 == mnv_pkg::CH_SLASH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (take_s1) begin
			st_q <= st_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= load_out;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			code_q <= code_nx;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, code_q, (code_q == mnv_pkg::ERR_NONE)};

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && is_end && out_valid_q && !m_axis_tready))
		else $error("input stalled without a blocked terminator");

	a_clear_after_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (st_q == '0))
		else $error("running flags not cleared after verdict");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (code_q <= mnv_pkg::ERR_EMPTY_SEG))
		else $error("verdict code out of range");

	a_load_slot: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || m_axis_tready))
		else $error("verdict loaded over an untaken result");

endmodule

### tb/sv/tb_mailbox_name_validator_core.sv
// Self-checking testbench for mailbox_name_validator_core: a directed table, then random
// names, each verdict checked against the code typed in the table or else against a
// local model of the name rules. Depends on mnv_pkg and mailbox_name_validator_core.
module tb_mailbox_name_validator_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEMS      = 2000;
	localparam int QUIET_TAIL = 300;
	localparam int IDLE_LIMIT = 2000;
	localparam int DIR_N      = 29;

	typedef struct {
		logic [7:0] b;
		bit         typed;
		logic [2:0] code;
	} dir_row_t;

	typedef struct packed {
		bit         typed;
		logic [2:0] code;
	} typed_verdict_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       s_axis_tvalid = 1'b0;
	logic                       s_axis_tready;
	logic [mnv_pkg::DATA_W-1:0] s_axis_tdata = '0;
	logic                       m_axis_tvalid;
	logic                       m_axis_tready = 1'b0;
	logic [mnv_pkg::OUT_W-1:0]  m_axis_tdata;

	mailbox_name_validator_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// running name flags of the local model
	logic       got_byte;
	logic       lead_slash;
	logic       last_slash;
	logic       utf_bad;
	logic [1:0] cont_need;
	logic [2:0] cont_cls;
	logic       c2_pending;
	logic       ctrl_hit;
	logic [1:0] pattern;

	logic [2:0]     verdicts_due[$];
	typed_verdict_t typed_verdicts[$];
	logic [7:0]     name_bytes[$];

	bit   quiet = 1'b0;
	int   ready_hold = 0;
	int   errors = 0;
	int   bytes_sent = 0;
	int   names_done = 0;
	int   verdicts_seen = 0;
	int   idle_cycles = 0;
	int   code_hits[7];
	bit   fired;
	logic [2:0]     want;
	typed_verdict_t tv;

	dir_row_t dir_rows[DIR_N] = '{
		'{8'h00, 1'b1, mnv_pkg::ERR_EMPTY},
		'{8'h61, 1'b0, mnv_pkg::ERR_NONE}, '{8'h00, 1'b1, mnv_pkg::ERR_NONE},
		'{mnv_pkg::CH_SLASH, 1'b0, mnv_pkg::ERR_NONE}, '{8'h00, 1'b1, mnv_pkg::ERR_EDGE},
		'{8'hC0, 1'b0, mnv_pkg::ERR_NONE}, '{8'h00, 1'b1, mnv_pkg::ERR_UTF8},
		'{8'hFF, 1'b0, mnv_pkg::ERR_NONE}, '{8'h00, 1'b1, mnv_pkg::ERR_UTF8},
		'{8'h01, 1'b0, mnv_pkg::ERR_NONE}, '{8'h00, 1'b1, mnv_pkg::ERR_CONTROL},
		'{mnv_pkg::CH_STAR, 1'b0, mnv_pkg::ERR_NONE}, '{8'h00, 1'b1, mnv_pkg::ERR_WILDCARD},
		'{8'h61, 1'b0, mnv_pkg::ERR_NONE},
		'{mnv_pkg::CH_SLASH, 1'b0, mnv_pkg::ERR_NONE},
		'{mnv_pkg::CH_SLASH, 1'b0, mnv_pkg::ERR_NONE},
		'{8'h62, 1'b0, mnv_pkg::ERR_NONE}, '{8'h00, 1'b1, mnv_pkg::ERR_EMPTY_SEG},
		'{8'hE0, 1'b0, mnv_pkg::ERR_NONE}, '{8'h80, 1'b0, mnv_pkg::ERR_NONE},
		'{8'h80, 1'b0, mnv_pkg::ERR_NONE},
		'{8'h00, 1'b1, mnv_pkg::ERR_UTF8},
		'{8'hED, 1'b0, mnv_pkg::ERR_NONE}, '{8'hA0, 1'b0, mnv_pkg::ERR_NONE},
		'{8'h80, 1'b0, mnv_pkg::ERR_NONE},
		'{8'h00, 1'b1, mnv_pkg::ERR_UTF8},
		'{8'hC2, 1'b0, mnv_pkg::ERR_NONE}, '{8'h80, 1'b0, mnv_pkg::ERR_NONE},
		'{8'h00, 1'b0, mnv_pkg::ERR_NONE}
	};

	task automatic clear_name();
		got_byte   = 1'b0;
		lead_slash = 1'b0;
		last_slash = 1'b0;
		utf_bad    = 1'b0;
		cont_need  = 2'd0;
		cont_cls   = mnv_pkg::CLS_FULL;
		c2_pending = 1'b0;
		ctrl_hit   = 1'b0;
		pattern    = mnv_pkg::PAT_NONE;
	endtask

	function automatic bit in_window(input logic [7:0] b, input logic [2:0] cls);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = 8'h80;
		hi = 8'hBF;
		if (cls == mnv_pkg::CLS_A0BF) lo = 8'hA0;
		else if (cls == mnv_pkg::CLS_809F) hi = 8'h9F;
		else if (cls == mnv_pkg::CLS_90BF) lo = 8'h90;
		else if (cls == mnv_pkg::CLS_808F) hi = 8'h8F;
		return (b >= lo) && (b <= hi);
	endfunction

	task automatic advance_name(input logic [7:0] b);
		if (!utf_bad) begin
			if (cont_need == 2'd0) begin
				cont_cls   = mnv_pkg::CLS_FULL;
				c2_pending = 1'b0;
				if (b < 8'h80) begin
					if (b < 8'h20 || b == 8'h7F) ctrl_hit = 1'b1;
				end else if (b < 8'hC2) begin
					utf_bad = 1'b1;
				end else if (b <= 8'hDF) begin
					cont_need  = 2'd1;
					c2_pending = (b == 8'hC2);
				end else if (b <= 8'hEF) begin
					cont_need = 2'd2;
					if (b == 8'hE0) cont_cls = mnv_pkg::CLS_A0BF;
					else if (b == 8'hED) cont_cls = mnv_pkg::CLS_809F;
				end else if (b <= 8'hF4) begin
					cont_need = 2'd3;
					if (b == 8'hF0) cont_cls = mnv_pkg::CLS_90BF;
					else if (b == 8'hF4) cont_cls = mnv_pkg::CLS_808F;
				end else begin
					utf_bad = 1'b1;
				end
			end else if (!in_window(b, cont_cls)) begin
				utf_bad = 1'b1;
			end else begin
				if (c2_pending && b <= 8'h9F) ctrl_hit = 1'b1;
				c2_pending = 1'b0;
				cont_cls   = mnv_pkg::CLS_FULL;
				cont_need  = cont_need - 2'd1;
			end
		end
		if (pattern == mnv_pkg::PAT_NONE) begin
			if (b == mnv_pkg::CH_STAR || b == mnv_pkg::CH_PERCENT)
				pattern = mnv_pkg::PAT_WILDCARD;
			else if (b == mnv_pkg::CH_SLASH && last_slash)
				pattern = mnv_pkg::PAT_DSLASH;
		end
		if (!got_byte && b == mnv_pkg::CH_SLASH) lead_slash = 1'b1;
		got_byte   = 1'b1;
		last_slash = (b == mnv_pkg::CH_SLASH);
	endtask

	function automatic logic [2:0] name_verdict();
		if (!got_byte) return mnv_pkg::ERR_EMPTY;
		if (utf_bad || cont_need != 2'd0) return mnv_pkg::ERR_UTF8;
		if (lead_slash || last_slash) return mnv_pkg::ERR_EDGE;
		if (ctrl_hit) return mnv_pkg::ERR_CONTROL;
		if (pattern == mnv_pkg::PAT_WILDCARD) return mnv_pkg::ERR_WILDCARD;
		if (pattern == mnv_pkg::PAT_DSLASH) return mnv_pkg::ERR_EMPTY_SEG;
		return mnv_pkg::ERR_NONE;
	endfunction

	task automatic push_byte(input logic [7:0] b, input bit typed, input logic [2:0] code);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		if (b == mnv_pkg::CH_END) typed_verdicts.push_back({typed, code});
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic drain_verdicts();
		s_axis_tvalid <= 1'b0;
		while (verdicts_due.size() != 0) @(negedge clk);
		@(negedge clk);
	endtask

	task automatic compose_name(input bit broken);
		int pieces;
		int pick;
		logic [7:0] lead;
		name_bytes.delete();
		pieces = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 8);
		repeat (pieces) begin
			pick = broken ? $urandom_range(0, 99) : $urandom_range(0, 88);
			if (pick < 45) begin
				name_bytes.push_back(8'($urandom_range(8'h30, 8'h7A)));
			end else if (pick < 60) begin
				name_bytes.push_back(8'($urandom_range(8'hC2, 8'hDF)));
				name_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
			end else if (pick < 70) begin
				lead = 8'($urandom_range(8'hE0, 8'hEF));
				name_bytes.push_back(lead);
				if (lead == 8'hE0) name_bytes.push_back(8'($urandom_range(8'hA0, 8'hBF)));
				else if (lead == 8'hED) name_bytes.push_back(8'($urandom_range(8'h80, 8'h9F)));
				else name_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
				name_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
			end else if (pick < 77) begin
				lead = 8'($urandom_range(8'hF0, 8'hF4));
				name_bytes.push_back(lead);
				if (lead == 8'hF0) name_bytes.push_back(8'($urandom_range(8'h90, 8'hBF)));
				else if (lead == 8'hF4) name_bytes.push_back(8'($urandom_range(8'h80, 8'h8F)));
				else name_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
				name_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
				name_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
			end else if (pick < 83) begin
				name_bytes.push_back(mnv_pkg::CH_SLASH);
			end else if (pick < 85) begin
				name_bytes.push_back($urandom_range(0, 1) ? mnv_pkg::CH_STAR : mnv_pkg::CH_PERCENT);
			end else if (pick < 87) begin
				name_bytes.push_back($urandom_range(0, 3) == 0 ? 8'h7F
					: 8'($urandom_range(1, 31)));
			end else if (pick < 89) begin
				name_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
			end else if (pick < 93) begin
				name_bytes.push_back(8'($urandom_range(1, 255)));
			end else if (pick < 96) begin
				name_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
			end else if (pick < 98) begin
				name_bytes.push_back(8'($urandom_range(8'hC2, 8'hF4)));
			end else if (pick < 99) begin
				if ($urandom_range(0, 1)) begin
					name_bytes.push_back(8'hE0);
					name_bytes.push_back(8'($urandom_range(8'h80, 8'h9F)));
				end else begin
					name_bytes.push_back(8'hED);
					name_bytes.push_back(8'($urandom_range(8'hA0, 8'hBF)));
				end
			end else begin
				case ($urandom_range(0, 2))
					0: begin
						name_bytes.push_back(8'hF4);
						name_bytes.push_back(8'($urandom_range(8'h90, 8'hBF)));
					end
					1: begin
						name_bytes.push_back(8'hF0);
						name_bytes.push_back(8'($urandom_range(8'h80, 8'h8F)));
					end
					default: begin
						name_bytes.push_back(8'($urandom_range(0, 1) ? $urandom_range(8'hC0, 8'hC1)
							: $urandom_range(8'hF5, 8'hFF)));
					end
				endcase
			end
		end
	endtask

	always @(negedge clk) begin
		if (ready_hold != 0) begin
			ready_hold    <= ready_hold - 1;
			m_axis_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			ready_hold    <= $urandom_range(0, 9);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			fired = 1'b0;
			if (s_axis_tvalid && s_axis_tready) begin
				fired = 1'b1;
				if (s_axis_tdata == mnv_pkg::CH_END) begin
					want = name_verdict();
					if (typed_verdicts.size() != 0) begin
						tv = typed_verdicts.pop_front();
						if (tv.typed) want = tv.code;
					end
					verdicts_due.push_back(want);
					clear_name();
					names_done++;
				end else begin
					advance_name(s_axis_tdata);
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				fired = 1'b1;
				verdicts_seen++;
				if (verdicts_due.size() == 0) begin
					$error("verdict with none expected: tdata %h", m_axis_tdata);
					errors++;
				end else begin
					want = verdicts_due.pop_front();
					code_hits[want]++;
					if (m_axis_tdata[0] !== (want == mnv_pkg::ERR_NONE)) begin
						$error("name_ok: expected %0b, actual %0b", want == mnv_pkg::ERR_NONE,
							m_axis_tdata[0]);
						errors++;
					end
					if (m_axis_tdata[3:1] !== want) begin
						$error("error_code: expected %0d, actual %0d", want, m_axis_tdata[3:1]);
						errors++;
					end
					if (m_axis_tdata[mnv_pkg::OUT_W-1:4] !== '0) begin
						$error("pad: expected 0, actual %h", m_axis_tdata[mnv_pkg::OUT_W-1:4]);
						errors++;
					end
				end
			end
			idle_cycles = fired ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		clear_name();
		foreach (code_hits[k]) code_hits[k] = 0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int r = 0; r < DIR_N; r++)
			push_byte(dir_rows[r].b, dir_rows[r].typed, dir_rows[r].code);
		drain_verdicts();

		while (bytes_sent < ITEMS) begin
			if (bytes_sent >= ITEMS - QUIET_TAIL) quiet = 1'b1;
			compose_name($urandom_range(0, 99) < 15);
			foreach (name_bytes[k]) push_byte(name_bytes[k], 1'b0, mnv_pkg::ERR_NONE);
			push_byte(mnv_pkg::CH_END, 1'b0, mnv_pkg::ERR_NONE);
			if (names_done % 40 == 0) drain_verdicts();
		end

		s_axis_tvalid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Streamed %0d bytes forming %0d names; %0d verdicts compared, %0d mismatches",
			bytes_sent, names_done, verdicts_seen, errors);
		$display("Verdicts per code (ok..empty segment): %0d %0d %0d %0d %0d %0d %0d",
			code_hits[0], code_hits[1], code_hits[2], code_hits[3], code_hits[4],
			code_hits[5], code_hits[6]);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
